// ===== rtl/core/gdda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_pkg
// Types and constants shared by the grid raycaster core.
// ----------------------------------------------------------------------------
package gdda_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 200;
    localparam int DEF_MAP_SIZE      = 8;

    localparam int MAP_W      = 24;
    localparam int DIST_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

    localparam logic [MAP_W-1:0] MAP_RESET [8] = '{
        24'd2396745, 24'd2097153, 24'd2171201, 24'd2097473,
        24'd2195457, 24'd2197761, 24'd2097153, 24'd2396745
    };

    typedef struct packed {
        logic [8:0]         column;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] view_dir_x;
        logic signed [15:0] view_dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
    } gdda_in_t;

    typedef struct packed {
        logic [8:0]  column_out;
        logic [7:0]  wall_top;
        logic [7:0]  wall_bottom;
        logic [15:0] wall_span;
        logic [2:0]  wall_color;
        logic        hit_side;
        logic        escaped;
    } gdda_out_t;

endpackage

// ===== rtl/core/gdda_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdda_div
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// ----------------------------------------------------------------------------
module gdda_div
    import gdda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg[31:0], quo_reg[47]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/grid_dda_raycast_column_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dda_raycast_column_core
// One ray per item: camera ray, step distances, DDA walk over the 8x8 map
// and wall height, all on one shared multiplier and one serial divider.
// Sequence: camera ray, two step divisions, the DDA walk, and a height
// division for a wall hit at a nonzero distance; a ray with no hit or a
// zero distance skips the height division.
// s_ready is low while an item is worked, so a new item is taken only once
// the last one is finished; a finished result waits in its own register.
// Reset: synchronous active low, clears control and loads the default map.
// ----------------------------------------------------------------------------
module grid_dda_raycast_column_core
    import gdda_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int MAP_SIZE      = DEF_MAP_SIZE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gdda_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gdda_out_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAP_W-1:0]     cfg_data
);

    localparam int H      = SCREEN_HEIGHT;
    localparam int HALF_H = H / 2;
    localparam logic [15:0] HALF_C = 16'(HALF_H);
    localparam logic [15:0] LAST_C = 16'(H - 1);
    localparam logic [15:0] MID_C  = (HALF_C > LAST_C) ? LAST_C : HALF_C;
    localparam int MAX_STEPS = 2 * MAP_SIZE + 2;
    localparam longint CAM_K = ((longint'(1) << 36) + longint'(SCREEN_WIDTH) - 1)
                               / longint'(SCREEN_WIDTH);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CAM   = 11'b00000000010,
        S_RX    = 11'b00000000100,
        S_RY    = 11'b00000001000,
        S_DX    = 11'b00000010000,
        S_DY    = 11'b00000100000,
        S_SX    = 11'b00001000000,
        S_SY    = 11'b00010000000,
        S_WALK  = 11'b00100000000,
        S_LH    = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [MAP_W-1:0] map_reg [8];
    gdda_in_t  in_reg;
    gdda_out_t out_reg;
    logic out_valid_reg;
    logic out_free;
    logic signed [24:0] cam_reg;
    logic signed [35:0] rx_reg, ry_reg;
    logic [DIST_W-1:0] ddx_reg, ddy_reg, sdx_reg, sdy_reg;
    logic signed [4:0] mx_reg, my_reg;
    logic side_reg, esc_reg, hit_reg;
    logic [2:0] color_reg;
    logic [4:0] step_reg;
    logic div_go_reg;

    // Shared multiplier.
    logic signed [35:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [61:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic div_done;
    logic [47:0] div_q, div_n;
    logic [31:0] div_d;
    logic [35:0] abs_r;

    gdda_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .dividend(div_n), .divisor(div_d), .done(div_done), .quotient(div_q)
    );

    logic [12:0] fx, fy;
    assign fx = in_reg.pos_x[12:0];
    assign fy = in_reg.pos_y[12:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CAM: begin mul_a = 36'(CAM_K); mul_b = 25'(in_reg.column); end
            S_RX: begin mul_a = 36'(in_reg.plane_x); mul_b = cam_reg; end
            S_RY: begin mul_a = 36'(in_reg.plane_y); mul_b = cam_reg; end
            S_SX: begin
                mul_a = rx_reg[35] ? 36'(fx) : 36'(14'h2000 - {1'b0, fx});
                mul_b = $signed({1'b0, ddx_reg});
            end
            S_SY: begin
                mul_a = ry_reg[35] ? 36'(fy) : 36'(14'h2000 - {1'b0, fy});
                mul_b = $signed({1'b0, ddy_reg});
            end
            default: ;
        endcase
    end

    logic [DIST_W-1:0] perp;
    always_comb begin
        perp = side_reg ? (sdy_reg - ddy_reg) : (sdx_reg - ddx_reg);
        abs_r = '0;
        div_n = 48'd1 << 32;
        div_d = 32'd1;
        unique case (state_reg)
            S_DX: begin
                abs_r = rx_reg[35] ? 36'(-rx_reg) : rx_reg;
                div_d = (abs_r[35:32] != 0) ? 32'hFFFFFFFF : abs_r[31:0];
            end
            S_DY: begin
                abs_r = ry_reg[35] ? 36'(-ry_reg) : ry_reg;
                div_d = (abs_r[35:32] != 0) ? 32'hFFFFFFFF : abs_r[31:0];
            end
            S_LH: begin
                div_n = 48'(H) << 16;
                div_d = 32'(perp);
            end
            default: ;
        endcase
    end

    // Walk step.
    logic step_y;
    logic [24:0] sum;
    logic signed [4:0] nmx, nmy;
    logic out_map;
    logic [2:0] cell_val;
    logic [MAP_W-1:0] row;
    always_comb begin
        step_y = !(sdx_reg < sdy_reg);
        sum = step_y ? ({1'b0, sdy_reg} + {1'b0, ddy_reg})
                     : ({1'b0, sdx_reg} + {1'b0, ddx_reg});
        nmx = mx_reg;
        nmy = my_reg;
        if (step_y) nmy = ry_reg[35] ? my_reg - 5'sd1 : my_reg + 5'sd1;
        else        nmx = rx_reg[35] ? mx_reg - 5'sd1 : mx_reg + 5'sd1;
        out_map = nmx[4] || nmy[4] || nmx[3] || nmy[3];
        row = map_reg[nmx[2:0]];
        cell_val = 3'(row >> (3 * nmy[2:0]));
    end

    logic [15:0] lh_sat, half_lh, ds, de;
    always_comb begin
        lh_sat = (div_q[47:16] != 0) ? 16'hFFFF : div_q[15:0];
        if (perp == 0) lh_sat = 16'hFFFF;
        half_lh = lh_sat >> 1;
        ds = (half_lh > HALF_C) ? 16'd0 : HALF_C - half_lh;
        de = HALF_C + half_lh;
        if (de > LAST_C) de = LAST_C;
        if (ds > LAST_C) ds = LAST_C;
    end

    logic signed [61:0] sh14;
    logic [48:0] sd_raw;
    assign sh14 = mul_p >>> 14;
    assign sd_raw = 49'(mul_p[61:0] >> 13);

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_CAM;
            S_CAM:  state_next = S_RX;
            S_RX:   state_next = S_RY;
            S_RY:   state_next = S_DX;
            S_DX:   if (div_done) state_next = S_DY;
            S_DY:   if (div_done) state_next = S_SX;
            S_SX:   state_next = S_SY;
            S_SY:   state_next = S_WALK;
            S_WALK: if (hit_reg || esc_reg || step_reg == 5'(MAX_STEPS))
                        state_next = (hit_reg && perp != 0) ? S_LH : S_OUT;
            S_LH:   if (div_done) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
            for (int i = 0; i < 8; i++) map_reg[i] <= MAP_RESET[i];
        end else begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == S_RY) || (state_reg == S_DX && div_done)
                       || (state_reg == S_WALK && state_next == S_LH);
            if (cfg_we) map_reg[cfg_index] <= cfg_data;
            if (state_reg == S_OUT && out_free) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) in_reg <= s_data;
            S_CAM: begin
                cam_reg <= 25'(mul_p >>> 19) - 25'sd65536;
                mx_reg <= {2'b00, in_reg.pos_x[15:13]};
                my_reg <= {2'b00, in_reg.pos_y[15:13]};
                step_reg <= '0;
                hit_reg <= 1'b0;
                esc_reg <= 1'b0;
                side_reg <= 1'b0;
                color_reg <= '0;
            end
            S_RX: rx_reg <= 36'(in_reg.view_dir_x) * 4 + 36'(sh14);
            S_RY: ry_reg <= 36'(in_reg.view_dir_y) * 4 + 36'(sh14);
            S_DX: if (div_done) ddx_reg <= (rx_reg == 0 || div_q[47:24] != 0)
                                           ? DIST_MAX : div_q[23:0];
            S_DY: if (div_done) ddy_reg <= (ry_reg == 0 || div_q[47:24] != 0)
                                           ? DIST_MAX : div_q[23:0];
            S_SX: sdx_reg <= (sd_raw[48:24] != 0) ? DIST_MAX : sd_raw[23:0];
            S_SY: sdy_reg <= (sd_raw[48:24] != 0) ? DIST_MAX : sd_raw[23:0];
            S_WALK: if (!(hit_reg || esc_reg || step_reg == 5'(MAX_STEPS))) begin
                step_reg <= step_reg + 5'd1;
                side_reg <= step_y;
                if (step_y) sdy_reg <= sum[24] ? DIST_MAX : sum[23:0];
                else        sdx_reg <= sum[24] ? DIST_MAX : sum[23:0];
                mx_reg <= nmx;
                my_reg <= nmy;
                if (out_map) esc_reg <= 1'b1;
                else begin
                    color_reg <= cell_val;
                    hit_reg <= (cell_val != 0);
                end
            end
            S_OUT: if (out_free) begin
                out_reg.column_out <= in_reg.column;
                out_reg.hit_side   <= side_reg;
                if (!hit_reg) begin
                    out_reg.escaped     <= 1'b1;
                    out_reg.wall_color  <= '0;
                    out_reg.wall_span   <= '0;
                    out_reg.wall_top    <= MID_C[7:0];
                    out_reg.wall_bottom <= MID_C[7:0];
                end else begin
                    out_reg.escaped     <= 1'b0;
                    out_reg.wall_color  <= color_reg;
                    out_reg.wall_span   <= lh_sat;
                    out_reg.wall_top    <= ds[7:0];
                    out_reg.wall_bottom <= de[7:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped");
    a_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> step_reg <= 5'(MAX_STEPS)) else $error("walk overrun");
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
`endif

endmodule
